[sv/min_trips_two_bin_subset_dp_top_macros.svh]
// Assertion macros used by the control block of the trip planner.
`ifndef MIN_TRIPS_TWO_BIN_SUBSET_DP_TOP_MACROS_SVH
`define MIN_TRIPS_TWO_BIN_SUBSET_DP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property checked while out of reset
`define MTBDP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every edge, reset included
`define MTBDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTBDP_ASSERT(lbl, clk, rstn, prop, msg)
`define MTBDP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/mtbdp_pkg.sv]
`default_nettype none
package mtbdp_pkg;

    localparam int MAX_ITEMS_DEF    = 10;
    localparam int MAX_CAPACITY_DEF = 128;

    localparam int WEIGHT_W   = 8;
    localparam int TRIPS_W    = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY_A = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY_B = 1'b1;

    // trip count meaning "no cover"
    localparam logic [TRIPS_W-1:0] NO_COVER = 4'd15;

    typedef struct packed {
        logic load;       // store accepted weight
        logic fit_start;  // last item taken: restart at mask 1
        logic fit_step;   // fold one item into the sum bitmap
        logic fit_write;  // store the one-trip flag, next mask
        logic dp_start;   // new DP mask: reset best and submask
        logic dp_issue;   // read one candidate submask
        logic dp_drain;   // fold last candidate, write DP entry
        logic out_done;   // result transfer complete
    } cmd_t;

    typedef struct packed {
        logic scan_last;  // item index at last loaded item
        logic mask_last;  // mask is the full set
        logic sub_zero;   // submask enumeration at its end
    } sts_t;

endpackage
`default_nettype wire

[sv/min_trips_two_bin_subset_dp_top.sv]
`default_nettype none
// Channel   Ports                                          Direction
// input     s_valid s_ready s_weight s_last_item           in
// result    m_valid m_ready m_min_trips m_impossible       out
// config    cfg_wr_en cfg_addr cfg_wdata                   in
//
// Weights are taken one per cycle while the block is loading; an item without
// last_item gives no result. The last item starts the walk: subset fit checks
// over every nonempty mask, then the DP, one candidate submask per cycle, set
// by the single read port of each table memory.
// Synchronous active-low reset clears the load count, capacities and control.
// No new item is taken from the last item until the result transfer completes.
module min_trips_two_bin_subset_dp_top
    import mtbdp_pkg::*;
#(
    parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [WEIGHT_W-1:0]   s_weight,
    input  wire logic                  s_last_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [TRIPS_W-1:0]         m_min_trips,
    output logic                       m_impossible
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: load, fit scan, DP walk, result transfer
    mtbdp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_item (s_last_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // weights, sum bitmap, one-trip and DP tables, result register
    mtbdp_dpath #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_weight     (s_weight),
        .cmd          (cmd),
        .sts          (sts),
        .m_min_trips  (m_min_trips),
        .m_impossible (m_impossible)
    );

endmodule
`default_nettype wire

[sv/mtbdp_dpath.sv]
`default_nettype none
module mtbdp_dpath
    import mtbdp_pkg::*;
#(
    parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [WEIGHT_W-1:0]   s_weight,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic [TRIPS_W-1:0]         m_min_trips,
    output logic                       m_impossible
);

    localparam int MASK_W = MAX_ITEMS;
    localparam int DEPTH  = 1 << MAX_ITEMS;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CAP_W  = $clog2(MAX_CAPACITY + 1);
    localparam int SUM_W  = $clog2(MAX_ITEMS * ((1 << WEIGHT_W) - 1) + 1);
    localparam int CW0    = (SUM_W > CAP_W) ? SUM_W : CAP_W;
    localparam int CMP_W  = (CW0 > WEIGHT_W) ? CW0 : WEIGHT_W;
    localparam int RCH_N  = MAX_CAPACITY + 1;

    logic [CFG_DATA_W-1:0] cap_a_reg, cap_b_reg;
    logic [WEIGHT_W-1:0]   weights_reg [MAX_ITEMS];
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [MASK_W-1:0]     sub_reg;
    logic [RCH_N-1:0]      reach_reg;
    logic [SUM_W-1:0]      total_reg;
    logic [TRIPS_W-1:0]    b_reg;
    logic                  pend_reg;
    logic                  zero_reg;
    logic                  ot_rd_reg;
    logic [TRIPS_W-1:0]    tr_rd_reg;
    logic [TRIPS_W-1:0]    res_trips_reg;
    logic                  res_imp_reg;

    logic                  ot_mem [DEPTH];
    logic [TRIPS_W-1:0]    trips_mem [DEPTH];

    logic [CMP_W-1:0]      ca_w, cb_w, wt_w, total_w;
    logic [WEIGHT_W-1:0]   wt;
    logic [RCH_N-1:0]      cap_mask, reach_upd, win;
    logic                  fit;
    logic [MASK_W-1:0]     full, low, rest, s_sel, tr_addr;
    logic [TRIPS_W-1:0]    tr_val, b_fin;
    logic                  take;

    // capacities clamped to the bitmap range
    assign ca_w = (CMP_W'(cap_a_reg) > CMP_W'(MAX_CAPACITY)) ?
                  CMP_W'(MAX_CAPACITY) : CMP_W'(cap_a_reg);
    assign cb_w = (CMP_W'(cap_b_reg) > CMP_W'(MAX_CAPACITY)) ?
                  CMP_W'(MAX_CAPACITY) : CMP_W'(cap_b_reg);

    assign wt      = weights_reg[idx_reg];
    assign wt_w    = CMP_W'(wt);
    assign total_w = CMP_W'(total_reg);

    always_comb begin
        for (int j = 0; j < RCH_N; j++) begin
            cap_mask[j] = (CMP_W'(j) <= ca_w);
            win[j] = reach_reg[j] && (CMP_W'(j) <= ca_w) && (CMP_W'(j) <= total_w)
                     && ((total_w - CMP_W'(j)) <= cb_w);
        end
    end

    assign reach_upd = reach_reg | ((reach_reg << wt) & cap_mask);
    assign fit       = |win;

    assign full    = MASK_W'(~({MASK_W{1'b1}} << count_reg));
    assign low     = mask_reg & (~mask_reg + MASK_W'(1));
    assign rest    = mask_reg ^ low;
    assign s_sel   = sub_reg | low;
    assign tr_addr = mask_reg ^ s_sel;

    assign tr_val = zero_reg ? '0 : tr_rd_reg;
    assign take   = pend_reg && ot_rd_reg && (tr_val != NO_COVER)
                    && ((tr_val + TRIPS_W'(1)) < b_reg);
    assign b_fin  = take ? (tr_val + TRIPS_W'(1)) : b_reg;

    assign sts.scan_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign sts.mask_last = (mask_reg == full);
    assign sts.sub_zero  = (sub_reg == '0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_a_reg <= '0;
            cap_b_reg <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CAPACITY_A: cap_a_reg <= cfg_wdata;
                    REG_CAPACITY_B: cap_b_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load && (count_reg < CNT_W'(MAX_ITEMS))) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_done) begin
                count_reg <= '0;
            end
            if (cmd.dp_start || cmd.dp_drain) begin
                pend_reg <= 1'b0;
            end else if (cmd.dp_issue) begin
                pend_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load && (count_reg < CNT_W'(MAX_ITEMS))) begin
            weights_reg[count_reg[IDX_W-1:0]] <= s_weight;
        end
        if (cmd.fit_start) begin
            mask_reg  <= MASK_W'(1);
        end
        if (cmd.fit_start || cmd.fit_write) begin
            reach_reg <= RCH_N'(1);
            total_reg <= '0;
            idx_reg   <= '0;
        end
        if (cmd.fit_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (mask_reg[idx_reg]) begin
                total_reg <= total_reg + SUM_W'(wt);
                if (wt_w <= ca_w) begin
                    reach_reg <= reach_upd;
                end
            end
        end
        if (cmd.fit_write) begin
            mask_reg <= sts.mask_last ? MASK_W'(1) : mask_reg + MASK_W'(1);
        end
        if (cmd.dp_start) begin
            b_reg   <= NO_COVER;
            sub_reg <= rest;
        end
        if (cmd.dp_issue) begin
            b_reg    <= b_fin;
            sub_reg  <= (sub_reg - MASK_W'(1)) & rest;
            zero_reg <= (tr_addr == '0);
        end
        if (cmd.dp_drain) begin
            b_reg         <= b_fin;
            res_imp_reg   <= (b_fin == NO_COVER);
            res_trips_reg <= (b_fin == NO_COVER) ? '0 : b_fin;
            if (!sts.mask_last) begin
                mask_reg <= mask_reg + MASK_W'(1);
            end
        end
    end

    // one-trip flags and DP table
    always_ff @(posedge aclk) begin
        if (cmd.fit_write) begin
            ot_mem[mask_reg] <= fit;
        end
        if (cmd.dp_issue) begin
            ot_rd_reg <= ot_mem[s_sel];
            tr_rd_reg <= trips_mem[tr_addr];
        end
        if (cmd.dp_drain) begin
            trips_mem[mask_reg] <= b_fin;
        end
    end

    assign m_min_trips  = res_trips_reg;
    assign m_impossible = res_imp_reg;

endmodule
`default_nettype wire

[sv/mtbdp_ctrl.sv]
`default_nettype none
`include "min_trips_two_bin_subset_dp_top_macros.svh"
module mtbdp_ctrl
    import mtbdp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_last_item,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_FIT_SCAN  = 3'd1;
    localparam logic [2:0] S_FIT_WRITE = 3'd2;
    localparam logic [2:0] S_DP_START  = 3'd3;
    localparam logic [2:0] S_DP_ISSUE  = 3'd4;
    localparam logic [2:0] S_DP_DRAIN  = 3'd5;
    localparam logic [2:0] S_OUT       = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_item) begin
                        cmd.fit_start = 1'b1;
                        state_next    = S_FIT_SCAN;
                    end
                end
            end
            S_FIT_SCAN: begin
                cmd.fit_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_FIT_WRITE;
                end
            end
            S_FIT_WRITE: begin
                cmd.fit_write = 1'b1;
                state_next    = sts.mask_last ? S_DP_START : S_FIT_SCAN;
            end
            S_DP_START: begin
                cmd.dp_start = 1'b1;
                state_next   = S_DP_ISSUE;
            end
            S_DP_ISSUE: begin
                cmd.dp_issue = 1'b1;
                if (sts.sub_zero) begin
                    state_next = S_DP_DRAIN;
                end
            end
            S_DP_DRAIN: begin
                cmd.dp_drain = 1'b1;
                state_next   = sts.mask_last ? S_OUT : S_DP_START;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.out_done = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    `MTBDP_ASSERT_ALWAYS(a_no_overlap, aclk, !(s_ready && m_valid), "ready and valid overlap")
    `MTBDP_ASSERT(a_out_to_load, aclk, aresetn, (m_valid && m_ready) |=> s_ready, "no return to load")
    `MTBDP_ASSERT(a_issue_drain, aclk, aresetn, (state_reg == S_DP_ISSUE && sts.sub_zero) |=> (state_reg == S_DP_DRAIN), "issue did not drain")
    `MTBDP_ASSERT(a_last_start, aclk, aresetn, (s_valid && s_ready && s_last_item) |=> (state_reg == S_FIT_SCAN), "last item did not start scan")

endmodule
`default_nettype wire

[verif/tb_min_trips_two_bin_subset_dp_top.sv]
`default_nettype none
// Trip planner bench: random and directed item sets, self-predicting scoreboard.

class trip_scoreboard;
    int unsigned     cap_a;
    int unsigned     cap_b;
    logic [7:0]      weights [10];
    int unsigned     loaded;
    logic [3:0]      trips_q [$];
    logic            impossible_q [$];
    int              errors;

    function new();
        cap_a  = 0;
        cap_b  = 0;
        loaded = 0;
        errors = 0;
    endfunction

    function void set_capacity(logic [0:0] idx, logic [7:0] val);
        if (idx == mtbdp_pkg::REG_CAPACITY_A) begin
            cap_a = val;
        end else begin
            cap_b = val;
        end
    endfunction

    // does the masked subset split into a part within ca and the rest within cb
    function bit splits_two_ways(int unsigned mask, int unsigned ca, int unsigned cb);
        bit          reach [0:128];
        int unsigned total;
        int unsigned wt;
        foreach (reach[k]) reach[k] = 1'b0;
        reach[0] = 1'b1;
        total    = 0;
        for (int i = 0; i < loaded; i++) begin
            if (!mask[i]) continue;
            wt     = weights[i];
            total += wt;
            if (wt > ca || wt == 0) continue;
            for (int j = ca; j >= wt; j--) begin
                if (reach[j - wt]) reach[j] = 1'b1;
            end
        end
        if (total > ca + cb) return 1'b0;
        for (int s = 0; s <= ca; s++) begin
            if (reach[s] && s <= total && total - s <= cb) return 1'b1;
        end
        return 1'b0;
    endfunction

    function void plan_trips();
        int unsigned ca;
        int unsigned cb;
        int unsigned full;
        int unsigned low;
        int unsigned rest;
        int unsigned sub;
        int unsigned best;
        int unsigned s;
        bit          one_trip [1024];
        int unsigned fewest [1024];
        ca   = (cap_a > 128) ? 128 : cap_a;
        cb   = (cap_b > 128) ? 128 : cap_b;
        full = (1 << loaded) - 1;
        for (int unsigned m = 1; m <= full; m++) one_trip[m] = splits_two_ways(m, ca, cb);
        fewest[0] = 0;
        for (int unsigned m = 1; m <= full; m++) begin
            low  = m & (~m + 1);
            rest = m ^ low;
            sub  = rest;
            best = mtbdp_pkg::NO_COVER;
            forever begin
                s = sub | low;
                if (one_trip[s] && fewest[m ^ s] != mtbdp_pkg::NO_COVER
                    && fewest[m ^ s] + 1 < best) begin
                    best = fewest[m ^ s] + 1;
                end
                if (sub == 0) break;
                sub = (sub - 1) & rest;
            end
            fewest[m] = best;
        end
        if (fewest[full] == mtbdp_pkg::NO_COVER) begin
            trips_q.push_back(4'd0);
            impossible_q.push_back(1'b1);
        end else begin
            trips_q.push_back(fewest[full][3:0]);
            impossible_q.push_back(1'b0);
        end
        loaded = 0;
    endfunction

    function void note_item(logic [7:0] w, logic last);
        if (loaded < 10) begin
            weights[loaded] = w;
            loaded++;
        end
        if (last) plan_trips();
    endfunction

    function void check_result(logic [3:0] trips, logic impossible);
        logic [3:0] exp_trips;
        logic       exp_imp;
        if (trips_q.size() == 0) begin
            $display("%0t: unexpected result trips=%0d impossible=%0b",
                     $time, trips, impossible);
            errors++;
            return;
        end
        exp_trips = trips_q.pop_front();
        exp_imp   = impossible_q.pop_front();
        if (trips !== exp_trips) begin
            $display("%0t: min_trips expected %0d actual %0d", $time, exp_trips, trips);
            errors++;
        end
        if (impossible !== exp_imp) begin
            $display("%0t: impossible expected %0b actual %0b", $time, exp_imp, impossible);
            errors++;
        end
    endfunction

    function int pending();
        return trips_q.size();
    endfunction
endclass

module tb_min_trips_two_bin_subset_dp_top;
    import mtbdp_pkg::*;

    // the longest DP walk (10 items) moves no transfer at all; the limit must exceed it
    localparam int QUIET_LIMIT = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [WEIGHT_W-1:0]   s_weight;
    logic                  s_last_item;
    logic                  m_valid;
    logic                  m_ready;
    logic [TRIPS_W-1:0]    m_min_trips;
    logic                  m_impossible;

    trip_scoreboard planner_sb;
    bit             calm;       // no idling on either side while set
    int             quiet_cycles;

    min_trips_two_bin_subset_dp_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_weight     (s_weight),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_trips  (m_min_trips),
        .m_impossible (m_impossible)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random back-pressure, check each result transfer, and a
    // watchdog on cycles in which neither channel moves a transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) planner_sb.check_result(m_min_trips, m_impossible);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_min_trips_two_bin_subset_dp_top NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    task automatic write_capacity(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        planner_sb.set_capacity(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // withdraw the input, wait for every outstanding result, then a little slack
    task automatic drain();
        s_valid <= 1'b0;
        while (planner_sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_item(logic [7:0] w, logic last);
        while (!calm && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_weight    <= w;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        planner_sb.note_item(w, last);
    endtask

    // weight mix: mostly in range, some tiny, rarely zero or over the top
    function automatic logic [7:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 3)  return 8'd0;
        if (r < 6)  return 8'($urandom_range(129, 255));
        if (r < 40) return 8'($urandom_range(1, 20));
        return 8'($urandom_range(1, 128));
    endfunction

    task automatic send_set(int n);
        for (int i = 0; i < n; i++) send_item(pick_weight(), i == n - 1);
    endtask

    int sent;
    int n;

    initial begin
        planner_sb  = new();
        calm        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_weight    = '0;
        s_last_item = 1'b0;
        m_ready     = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // zero capacities: nothing fits, no cover
        write_capacity(REG_CAPACITY_A, 8'd0);
        write_capacity(REG_CAPACITY_B, 8'd0);
        send_item(8'd1, 1'b1);
        drain();
        // full capacities: two heaviest items share one trip
        write_capacity(REG_CAPACITY_A, 8'd128);
        write_capacity(REG_CAPACITY_B, 8'd128);
        send_item(8'd128, 1'b0);
        send_item(8'd128, 1'b1);
        send_item(8'd0, 1'b1);      // zero weight alone
        send_item(8'd255, 1'b1);    // heavier than either carrier
        // overlong set: last two dropped, last flag on a dropped item
        for (int i = 0; i < 12; i++) send_item(8'(7 * i + 60), i == 11);
        drain();
        // capacities over the clamp point
        write_capacity(REG_CAPACITY_A, 8'd255);
        write_capacity(REG_CAPACITY_B, 8'd200);
        send_item(8'd127, 1'b0);
        send_item(8'd85, 1'b1);
        // sender holds off until every result is back
        drain();

        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_capacity(REG_CAPACITY_A, 8'd128);
                    write_capacity(REG_CAPACITY_B, 8'd128);
                end
                1: begin
                    write_capacity(REG_CAPACITY_A, 8'd0);
                    write_capacity(REG_CAPACITY_B, 8'd128);
                end
                2: begin
                    write_capacity(REG_CAPACITY_A, 8'd255);
                    write_capacity(REG_CAPACITY_B, 8'd0);
                end
                default: begin
                    write_capacity(REG_CAPACITY_A, 8'($urandom_range(0, 255)));
                    write_capacity(REG_CAPACITY_B, 8'($urandom_range(0, 255)));
                end
            endcase
            calm = (phase == 3);    // one long stretch with no idling
            while (sent < 275 * (phase + 1)) begin
                n = ($urandom_range(59) == 0) ? $urandom_range(10, 12)
                                              : $urandom_range(1, 5);
                send_set(n);
                sent += n;
            end
            calm = 1'b0;
        end
        drain();
        repeat (50) @(posedge aclk);
        if (planner_sb.errors == 0 && planner_sb.pending() == 0) begin
            $display("tb_min_trips_two_bin_subset_dp_top OK");
        end else begin
            $display("tb_min_trips_two_bin_subset_dp_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
